// ===== sv/first_seen_palette_indexer_assert.svh =====
// Assertion macros used by the palette indexer RTL.
`ifndef FIRST_SEEN_PALETTE_INDEXER_ASSERT_SVH
`define FIRST_SEEN_PALETTE_INDEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPSI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fpsi check failed");

// Next-cycle implication, checked outside reset.
`define FPSI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fpsi check failed");

`endif

// ===== sv/fpsi_pkg.sv =====
package fpsi_pkg;

    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int COLOR_W  = 24;
    localparam int TDATA_W  = 24;
    localparam int MDATA_W  = 24;
    localparam int MUSER_W  = 2;

    // word carried down the cell chain with one pixel
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               found;
        logic               is_new;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] colour;
    } chain_word_t;

endpackage

// ===== sv/first_seen_palette_indexer.sv =====
// Exact-color palette indexer, first-seen order.
// Input stream (s_): one RGB pixel per word, s_tlast marks the last pixel
// of an image. Output stream (m_): one word per pixel with the palette
// index, a new-entry flag, the sticky overflow flag and the entry count.
// The palette lives in a chain of PALETTE_ENTRIES cells, one color each.
// A pixel walks the chain one cell per cycle while the chain advances; the first free
// cell it meets without a prior match takes its color. Pixels follow each other in
// consecutive cycles while the chain advances, so throughput is one pixel per cycle;
// each passes the PALETTE_ENTRIES cell registers, then the output register.
// After the last pixel of an image passes a cell, that cell is freed, and
// the overflow flag clears once the last pixel leaves the output stage.
// Reset empties the palette and drops all words in flight.
// The whole chain advances as one: when m_tvalid is high and m_tready is
// low, every cell holds and s_tready is low.
module first_seen_palette_indexer #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpsi_pkg::TDATA_W-1:0]   s_tdata,  // red, green, blue
    input  logic                           s_tlast,  // last_pixel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpsi_pkg::MDATA_W-1:0]   m_tdata,  // palette_index, colour_count, pad
    output logic [fpsi_pkg::MUSER_W-1:0]   m_tuser   // is_new, overflow
);
    import fpsi_pkg::*;

    `include "first_seen_palette_indexer_assert.svh"

    chain_word_t       chain [PALETTE_ENTRIES+1];
    logic              advance;
    logic [IDX_W-1:0]  palette_index;
    logic              is_new;
    logic              overflow;
    logic [CNT_W-1:0]  colour_count;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb begin
        chain[0]        = '0;
        chain[0].valid  = s_tvalid;
        chain[0].last   = s_tlast;
        chain[0].colour = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        fpsi_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_index (IDX_W'(g)),
            .word_in    (chain[g]),
            .word_out   (chain[g+1])
        );
    end

    fpsi_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .word_in       (chain[PALETTE_ENTRIES]),
        .out_valid     (m_tvalid),
        .palette_index (palette_index),
        .is_new        (is_new),
        .overflow      (overflow),
        .colour_count  (colour_count)
    );

    assign m_tdata = {(MDATA_W-IDX_W-CNT_W)'(0), colour_count, palette_index};
    assign m_tuser = {overflow, is_new};

    `FPSI_ASSERT_NOW(a_new_no_ovf, aclk, aresetn, m_tvalid && is_new, !overflow)
    `FPSI_ASSERT_NOW(a_new_at_tail, aclk, aresetn, m_tvalid && is_new,
        palette_index == IDX_W'(colour_count - CNT_W'(1)))
    `FPSI_ASSERT_NOW(a_count_cap, aclk, aresetn, m_tvalid,
        colour_count <= CNT_W'(PALETTE_ENTRIES))
    `FPSI_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(colour_count) && $stable(overflow))

endmodule

// ===== sv/fpsi_cell.sv =====
module fpsi_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [fpsi_pkg::IDX_W-1:0] cell_index,
    input  fpsi_pkg::chain_word_t      word_in,
    output fpsi_pkg::chain_word_t      word_out
);
    import fpsi_pkg::*;

    logic                entry_valid_reg;
    logic                entry_valid_next;
    logic [COLOR_W-1:0]  colour_reg;
    chain_word_t         word_reg;
    chain_word_t         word_next;
    logic                hit;
    logic                claim;

    always_comb begin
        hit   = word_in.valid && entry_valid_reg && !word_in.found &&
                (colour_reg == word_in.colour);
        claim = word_in.valid && !entry_valid_reg && !word_in.found;

        word_next        = word_in;
        word_next.found  = word_in.found | hit | claim;
        word_next.is_new = word_in.is_new | claim;
        if (hit || claim) begin
            word_next.index = cell_index;
        end
        word_next.count = word_in.count + CNT_W'(entry_valid_reg | claim);

        entry_valid_next = entry_valid_reg;
        if (word_in.valid) begin
            if (word_in.last) begin
                entry_valid_next = 1'b0;
            end else if (claim) begin
                entry_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            word_reg        <= '0;
        end else if (advance) begin
            entry_valid_reg <= entry_valid_next;
            word_reg        <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && claim) begin
            colour_reg <= word_in.colour;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== sv/fpsi_out.sv =====
module fpsi_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  fpsi_pkg::chain_word_t      word_in,
    output logic                       out_valid,
    output logic [fpsi_pkg::IDX_W-1:0] palette_index,
    output logic                       is_new,
    output logic                       overflow,
    output logic [fpsi_pkg::CNT_W-1:0] colour_count
);
    import fpsi_pkg::*;

    logic              valid_reg;
    logic              ovf_seen_reg;
    logic              ovf_seen_next;
    logic              ovf_now;
    logic [IDX_W-1:0]  index_reg;
    logic              is_new_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  count_reg;

    always_comb begin
        ovf_now       = ovf_seen_reg | ~word_in.found;
        ovf_seen_next = ovf_seen_reg;
        if (word_in.valid) begin
            ovf_seen_next = word_in.last ? 1'b0 : ovf_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end else if (advance) begin
            valid_reg    <= word_in.valid;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            index_reg  <= word_in.found ? word_in.index : '0;
            is_new_reg <= word_in.is_new;
            ovf_reg    <= ovf_now;
            count_reg  <= word_in.count;
        end
    end

    assign out_valid     = valid_reg;
    assign palette_index = index_reg;
    assign is_new        = is_new_reg;
    assign overflow      = ovf_reg;
    assign colour_count  = count_reg;

endmodule
